FILE: hw/rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lookup block.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ALP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ALP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/alp_pkg.sv
// ------------------------------------------------------------------------
// Arc-length lookup package
// Types, widths and codes shared by the lookup controller and datapath.
// ------------------------------------------------------------------------
package alp_pkg;

   localparam int TBL_DEPTH = 1024;
   localparam int IDX_W     = $clog2(TBL_DEPTH);
   localparam int PTS_W     = 11;
   localparam int LEN_W     = 32;
   localparam int FRAC_W    = 17;
   localparam int FBITS     = 16;
   localparam int WANT_W    = FRAC_W + LEN_W;
   localparam int Q1_BITS   = 18;
   localparam int Q2_BITS   = 17;
   localparam int T_W       = IDX_W + FBITS + 1;
   localparam int CNT_W     = $clog2(Q1_BITS);

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_START     = 4'd2;
   localparam logic [3:0] OP_TOTAL     = 4'd3;
   localparam logic [3:0] OP_PROBE     = 4'd4;
   localparam logic [3:0] OP_CMP       = 4'd5;
   localparam logic [3:0] OP_BRACKET   = 4'd6;
   localparam logic [3:0] OP_LEFT      = 4'd7;
   localparam logic [3:0] OP_RIGHT     = 4'd8;
   localparam logic [3:0] OP_DIV1_INIT = 4'd9;
   localparam logic [3:0] OP_DIV_STEP  = 4'd10;
   localparam logic [3:0] OP_DIV2_INIT = 4'd11;
   localparam logic [3:0] OP_RESULT    = 4'd12;

   typedef struct packed {
      logic              action;
      logic [IDX_W-1:0]  entry_index;
      logic [LEN_W-1:0]  entry_length;
      logic [FRAC_W-1:0] distance_fraction;
   } req_type;

   typedef struct packed {
      logic [FRAC_W-1:0] time_fraction;
      logic [IDX_W-1:0]  bracket_index;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic open;
      logic eq;
      logic div_skip;
      logic out_free;
   } sts_type;

endpackage

FILE: hw/rtl/alp_ram.sv
// ------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ------------------------------------------------------------------------
module alp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/alp_ctrl.sv
// ------------------------------------------------------------------------
// Lookup controller
// Sequences table loads, the binary search, both divisions and the result.
// ------------------------------------------------------------------------
module alp_ctrl import alp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_TOTAL   = 4'd1;
   localparam logic [3:0] ST_PROBE   = 4'd2;
   localparam logic [3:0] ST_CMP     = 4'd3;
   localparam logic [3:0] ST_BRACKET = 4'd4;
   localparam logic [3:0] ST_LEFT    = 4'd5;
   localparam logic [3:0] ST_RIGHT   = 4'd6;
   localparam logic [3:0] ST_D1INIT  = 4'd7;
   localparam logic [3:0] ST_D1      = 4'd8;
   localparam logic [3:0] ST_D2INIT  = 4'd9;
   localparam logic [3:0] ST_D2      = 4'd10;
   localparam logic [3:0] ST_RESULT  = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_START;
                  state_in = sts.empty ? ST_RESULT : ST_TOTAL;
               end
            end
         end
         ST_TOTAL: begin
            cmd.op   = OP_TOTAL;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (sts.open) begin
               cmd.op   = OP_PROBE;
               state_in = ST_CMP;
            end else begin
               cmd.op   = OP_BRACKET;
               state_in = ST_LEFT;
            end
         end
         ST_CMP: begin
            cmd.op   = OP_CMP;
            state_in = sts.eq ? ST_BRACKET : ST_PROBE;
         end
         ST_BRACKET: begin
            cmd.op   = OP_BRACKET;
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            cmd.op   = OP_LEFT;
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            cmd.op   = OP_RIGHT;
            state_in = ST_D1INIT;
         end
         ST_D1INIT: begin
            cmd.op = OP_DIV1_INIT;
            if (sts.div_skip) begin
               state_in = ST_D2INIT;
            end else begin
               cnt_in   = CNT_W'(Q1_BITS - 1);
               state_in = ST_D1;
            end
         end
         ST_D1: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_D2INIT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_D2INIT: begin
            cmd.op   = OP_DIV2_INIT;
            cnt_in   = CNT_W'(Q2_BITS - 1);
            state_in = ST_D2;
         end
         ST_D2: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/alp_dpath.sv
// ------------------------------------------------------------------------
// Lookup datapath
// Length table, search bounds, bracket pair, shared serial divider and
// the result register.
// ------------------------------------------------------------------------
module alp_dpath import alp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [PTS_W-1:0] csr_wr_data,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic [PTS_W-1:0]   points_ff;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [WANT_W-1:0]  want_ff, want_in;
   logic [PTS_W-1:0]   lo_ff, lo_in, hp_ff, hp_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [LEN_W-1:0]   v_ff, v_in;
   logic [IDX_W-1:0]   left_ff, left_in, right_ff, right_in;
   logic               step_ff, step_in;
   logic [LEN_W-1:0]   lval_ff, lval_in;
   logic [WANT_W-1:0]  num_ff, num_in;
   logic [LEN_W-1:0]   width_ff, width_in;
   logic               zero_ff, zero_in;
   logic [WANT_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [Q1_BITS-1:0] quo_ff, quo_in;
   logic               empty_ff, empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [PTS_W-1:0]   n_used, last_full, span, mid_w, right_w;
   logic [IDX_W-1:0]   last;
   logic [FRAC_W-1:0]  frac_sat, s_sat;
   logic [WANT_W-1:0]  rd_scaled, v_scaled, l_scaled, prod;
   logic               go_back, over, ge;
   logic [IDX_W-1:0]   left_w;
   logic [T_W-1:0]     t_sum;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   logic [LEN_W-1:0]   rd_data;

   alp_ram #(
      .WIDTH (LEN_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_data.entry_length),
      .rd_data (rd_data)
   );

   assign n_used    = (points_ff > PTS_W'(TBL_DEPTH)) ? PTS_W'(TBL_DEPTH) : points_ff;
   assign last_full = n_used - PTS_W'(1);
   assign last      = last_full[IDX_W-1:0];
   assign frac_sat  = (req_data.distance_fraction > FRAC_ONE) ? FRAC_ONE
                                                              : req_data.distance_fraction;
   assign rd_scaled = WANT_W'({rd_data, FBITS'(0)});
   assign v_scaled  = WANT_W'({v_ff, FBITS'(0)});
   assign l_scaled  = WANT_W'({lval_ff, FBITS'(0)});
   assign prod      = WANT_W'(frac_ff) * WANT_W'(rd_data);
   assign span      = hp_ff - lo_ff - PTS_W'(1);
   assign mid_w     = lo_ff + (span >> 1);
   assign go_back   = (want_ff <= v_scaled) && (mid_ff != '0);
   assign left_w    = go_back ? (mid_ff - IDX_W'(1)) : mid_ff;
   assign right_w   = go_back ? PTS_W'(mid_ff) : (PTS_W'(mid_ff) + PTS_W'(1));
   assign over      = {1'b0, num_ff} >= {width_ff, Q1_BITS'(0)};
   assign ge        = rem_ff >= dvs_ff;
   assign s_sat     = (quo_ff > Q1_BITS'(FRAC_ONE)) ? FRAC_ONE : quo_ff[FRAC_W-1:0];
   assign t_sum     = T_W'({left_ff, FBITS'(0)}) + (step_ff ? T_W'(s_sat) : T_W'(0));

   assign ram_we = (cmd.op == OP_LOAD);

   always_comb begin
      case (cmd.op)
         OP_LOAD:    ram_addr = req_data.entry_index;
         OP_START:   ram_addr = last;
         OP_PROBE:   ram_addr = mid_w[IDX_W-1:0];
         OP_BRACKET: ram_addr = left_w;
         OP_LEFT:    ram_addr = right_ff;
         default:    ram_addr = '0;
      endcase
   end

   assign sts.empty    = (n_used == '0);
   assign sts.open     = (lo_ff < hp_ff);
   assign sts.eq       = (rd_scaled == want_ff);
   assign sts.div_skip = zero_ff || over;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      frac_in     = frac_ff;
      want_in     = want_ff;
      lo_in       = lo_ff;
      hp_in       = hp_ff;
      mid_in      = mid_ff;
      v_in        = v_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      step_in     = step_ff;
      lval_in     = lval_ff;
      num_in      = num_ff;
      width_in    = width_ff;
      zero_in     = zero_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      empty_in    = empty_ff;
      rsp_data_in = rsp_data_ff;
      case (cmd.op)
         OP_START: begin
            frac_in  = frac_sat;
            empty_in = (n_used == '0);
         end
         OP_TOTAL: begin
            want_in = prod;
            lo_in   = '0;
            hp_in   = n_used;
         end
         OP_PROBE: begin
            mid_in = mid_w[IDX_W-1:0];
         end
         OP_CMP: begin
            v_in = rd_data;
            if (rd_scaled < want_ff) begin
               lo_in = PTS_W'(mid_ff) + PTS_W'(1);
            end else begin
               hp_in = PTS_W'(mid_ff);
            end
         end
         OP_BRACKET: begin
            left_in = left_w;
            if (right_w > last_full) begin
               right_in = last;
               step_in  = (last != left_w);
            end else begin
               right_in = right_w[IDX_W-1:0];
               step_in  = (right_w[IDX_W-1:0] != left_w);
            end
         end
         OP_LEFT: begin
            lval_in = rd_data;
         end
         OP_RIGHT: begin
            zero_in  = (rd_data <= lval_ff) || (want_ff <= l_scaled);
            num_in   = want_ff - l_scaled;
            width_in = rd_data - lval_ff;
         end
         OP_DIV1_INIT: begin
            if (zero_ff) begin
               quo_in = '0;
            end else if (over) begin
               quo_in = Q1_BITS'(FRAC_ONE);
            end else begin
               rem_in = num_ff;
               dvs_in = WANT_W'({width_ff, (Q1_BITS - 1)'(0)});
               quo_in = '0;
            end
         end
         OP_DIV_STEP: begin
            rem_in = ge ? (rem_ff - dvs_ff) : rem_ff;
            dvs_in = dvs_ff >> 1;
            quo_in = {quo_ff[Q1_BITS-2:0], ge};
         end
         OP_DIV2_INIT: begin
            rem_in = WANT_W'(t_sum);
            dvs_in = WANT_W'({n_used, (Q2_BITS - 1)'(0)});
            quo_in = '0;
         end
         OP_RESULT: begin
            if (empty_ff) begin
               rsp_data_in.time_fraction = '0;
               rsp_data_in.bracket_index = '0;
               rsp_data_in.status        = STATUS_EMPTY;
            end else begin
               rsp_data_in.time_fraction = quo_ff[FRAC_W-1:0];
               rsp_data_in.bracket_index = left_ff;
               rsp_data_in.status        = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (cmd.op == OP_RESULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff    <= PTS_W'(TBL_DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            points_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff     <= frac_in;
      want_ff     <= want_in;
      lo_ff       <= lo_in;
      hp_ff       <= hp_in;
      mid_ff      <= mid_in;
      v_ff        <= v_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      step_ff     <= step_in;
      lval_ff     <= lval_in;
      num_ff      <= num_in;
      width_ff    <= width_in;
      zero_ff     <= zero_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/arc_length_to_parameter_lookup_top.sv
// ------------------------------------------------------------------------
// Arc-length to curve-parameter lookup
// Maps a fraction of total curve length to the curve parameter by binary
// search over a cumulative arc-length table and linear interpolation.
// ------------------------------------------------------------------------
// A load item writes one table entry; it gives no result. A query makes
// table probes, at most 11 for 1024 entries; when the interpolation
// interval is flat or the fraction saturates, the first division is
// skipped. An empty table skips the search and both divisions. A query
// is paced by the search, one probe at a time through the single-port
// table RAM, and by the shared divider, which retires one quotient bit
// per cycle for 18 bits of interpolation fraction and 17 bits of time.
// One item is processed at a time; a finished result waits in the output
// register while the next item is taken. The table has no reset and
// must be loaded before it is queried.
`include "assert_macros.svh"

module arc_length_to_parameter_lookup_top import alp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [PTS_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   alp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   alp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   `ALP_ASSERT_IMPLY(a_result_slot_free, clock, reset, cmd.op == OP_RESULT, sts.out_free)
   `ALP_ASSERT_NEXT(a_query_goes_busy, clock, reset, req_valid && req_ready && req_data.action == ACT_QUERY, !req_ready)
   `ALP_ASSERT_IMPLY(a_empty_gives_zero, clock, reset, rsp_valid && rsp_data.status == STATUS_EMPTY, rsp_data.time_fraction == '0 && rsp_data.bracket_index == '0)
   `ALP_ASSERT_IMPLY(a_time_in_range, clock, reset, rsp_valid, rsp_data.time_fraction <= FRAC_ONE)

endmodule
